/* hdl/gpr_pkg.sv */
package gpr_pkg;

  // fixed field widths
  localparam int unsigned CodeW   = 7;
  localparam int unsigned PosW    = 7;
  localparam int unsigned OrgW    = 16;
  localparam int unsigned DimW    = 13;
  localparam int unsigned MarginW = 10;
  localparam int unsigned BandW   = 2;

  // glyph geometry
  localparam int unsigned GlyphRows = 6;
  localparam int unsigned GlyphDots = 6;
  localparam int unsigned GlyphBits = GlyphRows * GlyphDots;
  localparam int unsigned SlotW     = $clog2(GlyphBits);
  localparam int unsigned RowCntW   = $clog2(GlyphRows);
  localparam int unsigned DotCntW   = $clog2(GlyphDots);

  // plot coordinates before margins, and page coordinates before clipping
  localparam int unsigned CoordW = 18;
  localparam int unsigned PageW  = 19;

  // configuration register indexes
  localparam logic [2:0] CfgPageHeight = 3'd0;
  localparam logic [2:0] CfgBandHeight = 3'd1;
  localparam logic [2:0] CfgPageWidth  = 3'd2;
  localparam logic [2:0] CfgTopMargin  = 3'd3;
  localparam logic [2:0] CfgLeftMargin = 3'd4;

  // band codes
  localparam logic [BandW-1:0] BandUpper  = 2'd0;
  localparam logic [BandW-1:0] BandMiddle = 2'd1;
  localparam logic [BandW-1:0] BandLower  = 2'd2;

  // glyph code used for control characters
  localparam logic [5:0] GlyphHash = 6'h23;

  typedef struct packed {
    logic [DimW-1:0]    page_height;
    logic [DimW-1:0]    band_height;
    logic [DimW-1:0]    page_width;
    logic [MarginW-1:0] top_margin;
    logic [MarginW-1:0] left_margin;
  } gpr_cfg_t;

  // one glyph slot in plot coordinates
  typedef struct packed {
    logic                     end_slot;
    logic                     hit;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } gpr_coord_t;

  // one glyph slot in page coordinates after clipping
  typedef struct packed {
    logic             end_slot;
    logic             hit;
    logic [DimW-1:0]  row;
    logic [DimW-1:0]  col;
    logic [BandW-1:0] band;
  } gpr_pix_t;

  // 6x6 font, row 0 in the top two octal digits, left dot in the msb of each row
  localparam logic [GlyphBits-1:0] FontRom [64] = '{
    36'o364146514635, 36'o142241774141, 36'o764176414176, 36'o364140404136,
    36'o764141414176, 36'o774076404077, 36'o774076404040, 36'o364140474136,
    36'o414177414141, 36'o040404040404, 36'o010101014136, 36'o414274444241,
    36'o404040404077, 36'o416355414141, 36'o416151454341, 36'o364141414136,
    36'o764141764040, 36'o364141454235, 36'o764141764241, 36'o364036014136,
    36'o370404040404, 36'o414141414136, 36'o414141412214, 36'o414141556341,
    36'o412214142241, 36'o211204040404, 36'o770204102077, 36'o161010101016,
    36'o402010040201, 36'o340404040434, 36'o041200000000, 36'o000000000077,
    36'o000000000000, 36'o101010100010, 36'o222200000000, 36'o227722227722,
    36'o365436155536, 36'o016264132340, 36'o142214244235, 36'o101000000000,
    36'o041010101004, 36'o100404040410, 36'o002214142200, 36'o001010761010,
    36'o000060602040, 36'o000000760000, 36'o000000006060, 36'o010204102040,
    36'o142222222214, 36'o041404040437, 36'o162101162037, 36'o162101160136,
    36'o222222370202, 36'o372020360136, 36'o172036212116, 36'o370102041020,
    36'o162116212116, 36'o162121170116, 36'o003030003030, 36'o003030001020,
    36'o000000000000, 36'o000000000000, 36'o000000000000, 36'o000000000000
  };

endpackage

/* hdl/glyph_pixel_rasterizer.sv */
// channel  handshake                payload
// input    in_valid_i/in_ready_o    char_code_i char_position_i origin_x_i origin_y_i vertical_i
// result   out_valid_o/out_ready_i  pixel_valid_o pixel_row_o pixel_col_o band_o last_o
// config   cfg_valid_i/cfg_ready_o  cfg_index_i cfg_data_i
//
// the slot sequencer walks the 6x6 glyph of each character one bit a cycle while the pipeline advances
// registers from a transfer in to its first result: glyph, s1, s2, s3, held pixel, output
// a drawn pixel is held until the next one or the last slot shows up
// reset clears all valid bits and loads the register defaults; config is always ready
// when the result register is full and not taken, every stage holds in place
module glyph_pixel_rasterizer #(
  parameter int unsigned MAX_CHARS  = 120,
  parameter int unsigned CELL_WIDTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gpr_pkg::CodeW-1:0]         char_code_i,
  input  logic [gpr_pkg::PosW-1:0]          char_position_i,
  input  logic signed [gpr_pkg::OrgW-1:0]   origin_x_i,
  input  logic signed [gpr_pkg::OrgW-1:0]   origin_y_i,
  input  logic                              vertical_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              pixel_valid_o,
  output logic [gpr_pkg::DimW-1:0]          pixel_row_o,
  output logic [gpr_pkg::DimW-1:0]          pixel_col_o,
  output logic [gpr_pkg::BandW-1:0]         band_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [gpr_pkg::DimW-1:0]          cfg_data_i
);

  gpr_pkg::gpr_cfg_t   cfg_q;
  logic                adv;
  logic                slot_valid;
  gpr_pkg::gpr_coord_t slot;
  logic                pix_valid;
  gpr_pkg::gpr_pix_t   pix;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_height <= gpr_pkg::DimW'(2040);
      cfg_q.band_height <= gpr_pkg::DimW'(680);
      cfg_q.page_width  <= gpr_pkg::DimW'(792);
      cfg_q.top_margin  <= '0;
      cfg_q.left_margin <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gpr_pkg::CfgPageHeight: cfg_q.page_height <= cfg_data_i;
        gpr_pkg::CfgBandHeight: cfg_q.band_height <= cfg_data_i;
        gpr_pkg::CfgPageWidth:  cfg_q.page_width  <= cfg_data_i;
        gpr_pkg::CfgTopMargin:  cfg_q.top_margin  <= cfg_data_i[gpr_pkg::MarginW-1:0];
        gpr_pkg::CfgLeftMargin: cfg_q.left_margin <= cfg_data_i[gpr_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  // glyph slots and plot coordinates
  gpr_slot_gen #(
    .MAX_CHARS  (MAX_CHARS),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_slot_gen (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .char_position_i (char_position_i),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .vertical_i      (vertical_i),
    .slot_valid_o    (slot_valid),
    .slot_o          (slot)
  );

  // page mapping, clipping and band
  gpr_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .cfg_i        (cfg_q),
    .slot_valid_i (slot_valid),
    .slot_i       (slot),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix)
  );

  // last-pixel detection and result register
  gpr_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_o         (adv),
    .pix_valid_i   (pix_valid),
    .pix_i         (pix),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_row_o   (pixel_row_o),
    .pixel_col_o   (pixel_col_o),
    .band_o        (band_o),
    .last_o        (last_o)
  );

endmodule

/* hdl/gpr_slot_gen.sv */
module gpr_slot_gen #(
  parameter int unsigned MAX_CHARS  = 120,
  parameter int unsigned CELL_WIDTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gpr_pkg::CodeW-1:0]           char_code_i,
  input  logic [gpr_pkg::PosW-1:0]            char_position_i,
  input  logic signed [gpr_pkg::OrgW-1:0]     origin_x_i,
  input  logic signed [gpr_pkg::OrgW-1:0]     origin_y_i,
  input  logic                                vertical_i,
  output logic                                slot_valid_o,
  output gpr_pkg::gpr_coord_t                 slot_o
);

  localparam int unsigned OfsW = gpr_pkg::PosW + $clog2(CELL_WIDTH);

  logic                                  gen_v_q;
  logic [gpr_pkg::GlyphBits-1:0]         glyph_q;
  logic [OfsW-1:0]                       base_q;
  logic signed [gpr_pkg::OrgW-1:0]       ox_q;
  logic signed [gpr_pkg::OrgW-1:0]       oy_q;
  logic                                  vert_q;
  logic [gpr_pkg::SlotW-1:0]             cnt_q;
  logic [gpr_pkg::RowCntW-1:0]           row_q;
  logic [gpr_pkg::DotCntW-1:0]           dot_q;

  logic                                  s1_v_q;
  gpr_pkg::gpr_coord_t                   s1_q;
  gpr_pkg::gpr_coord_t                   s1_d;

  logic                                  final_slot;
  logic                                  accept;
  logic [5:0]                            glyph_idx;
  logic [gpr_pkg::CodeW-1:0]             code_up;
  logic [OfsW-1:0]                       ofs;
  logic signed [gpr_pkg::CoordW-1:0]     ox_ext;
  logic signed [gpr_pkg::CoordW-1:0]     oy_ext;
  logic signed [gpr_pkg::CoordW-1:0]     ofs_ext;
  logic signed [gpr_pkg::CoordW-1:0]     row_ext;

  // the next character is taken as the current one leaves its last slot
  assign final_slot = (cnt_q == gpr_pkg::SlotW'(gpr_pkg::GlyphBits - 1));
  assign in_ready_o = adv_i && (!gen_v_q || final_slot);
  assign accept     = in_valid_i && in_ready_o;

  // fold lower case onto upper case and control codes onto the hash glyph
  always_comb begin
    code_up = (char_code_i >= 7'h60) ? (char_code_i - 7'h20) : char_code_i;
    if (char_code_i < 7'h20) begin
      glyph_idx = gpr_pkg::GlyphHash;
    end else begin
      glyph_idx = code_up[5:0];
    end
  end

  // slot sequencer: one glyph bit per cycle while adv_i is high, row-major
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_v_q <= 1'b0;
    end else if (adv_i) begin
      if (accept) begin
        gen_v_q <= 1'b1;
      end else if (final_slot) begin
        gen_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (accept) begin
        glyph_q <= (char_position_i < gpr_pkg::PosW'(MAX_CHARS)) ?
                   gpr_pkg::FontRom[glyph_idx] : '0;
        base_q  <= OfsW'(char_position_i) * OfsW'(CELL_WIDTH);
        ox_q    <= origin_x_i;
        oy_q    <= origin_y_i;
        vert_q  <= vertical_i;
        cnt_q   <= '0;
        row_q   <= '0;
        dot_q   <= '0;
      end else if (gen_v_q) begin
        glyph_q <= {glyph_q[gpr_pkg::GlyphBits-2:0], 1'b0};
        cnt_q   <= cnt_q + 1'b1;
        if (dot_q == gpr_pkg::DotCntW'(gpr_pkg::GlyphDots - 1)) begin
          dot_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          dot_q <= dot_q + 1'b1;
        end
      end
    end
  end

  // plot coordinates of the current slot
  always_comb begin
    ofs     = base_q + OfsW'(dot_q);
    ox_ext  = gpr_pkg::CoordW'(ox_q);
    oy_ext  = gpr_pkg::CoordW'(oy_q);
    ofs_ext = $signed(gpr_pkg::CoordW'(ofs));
    row_ext = $signed(gpr_pkg::CoordW'(row_q));
    s1_d.end_slot = final_slot;
    s1_d.hit      = glyph_q[gpr_pkg::GlyphBits-1];
    if (vert_q) begin
      s1_d.px = ox_ext + row_ext;
      s1_d.py = oy_ext + ofs_ext;
    end else begin
      s1_d.px = ox_ext + ofs_ext;
      s1_d.py = oy_ext - row_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv_i) begin
      s1_v_q <= gen_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= s1_d;
    end
  end

  assign slot_valid_o = s1_v_q;
  assign slot_o       = s1_q;

endmodule

/* hdl/gpr_map.sv */
module gpr_map (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  gpr_pkg::gpr_cfg_t    cfg_i,
  input  logic                 slot_valid_i,
  input  gpr_pkg::gpr_coord_t  slot_i,
  output logic                 pix_valid_o,
  output gpr_pkg::gpr_pix_t    pix_o
);

  logic                             s2_v_q;
  logic                             s2_end_q;
  logic                             s2_hit_q;
  logic signed [gpr_pkg::PageW-1:0] s2_row_q;
  logic signed [gpr_pkg::PageW-1:0] s2_col_q;

  logic                             s3_v_q;
  gpr_pkg::gpr_pix_t                s3_q;
  gpr_pkg::gpr_pix_t                s3_d;

  logic signed [gpr_pkg::PageW-1:0] ph_ext;
  logic signed [gpr_pkg::PageW-1:0] pw_ext;
  logic signed [gpr_pkg::PageW-1:0] bh_ext;
  logic signed [gpr_pkg::PageW-1:0] bh2_ext;
  logic signed [gpr_pkg::PageW-1:0] tm_ext;
  logic signed [gpr_pkg::PageW-1:0] lm_ext;
  logic                             inside_page;

  assign ph_ext  = $signed(gpr_pkg::PageW'(cfg_i.page_height));
  assign pw_ext  = $signed(gpr_pkg::PageW'(cfg_i.page_width));
  assign bh_ext  = $signed(gpr_pkg::PageW'(cfg_i.band_height));
  assign bh2_ext = $signed({bh_ext[gpr_pkg::PageW-2:0], 1'b0});
  assign tm_ext  = $signed(gpr_pkg::PageW'(cfg_i.top_margin));
  assign lm_ext  = $signed(gpr_pkg::PageW'(cfg_i.left_margin));

  // flip and margins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv_i) begin
      s2_v_q <= slot_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_end_q <= slot_i.end_slot;
      s2_hit_q <= slot_i.hit;
      s2_row_q <= ph_ext - gpr_pkg::PageW'(slot_i.py) + tm_ext;
      s2_col_q <= gpr_pkg::PageW'(slot_i.px) + lm_ext;
    end
  end

  // clipping and band selection
  always_comb begin
    inside_page   = (s2_row_q >= 0) && (s2_row_q <= ph_ext) &&
                    (s2_col_q >= 0) && (s2_col_q <= pw_ext);
    s3_d.end_slot = s2_end_q;
    s3_d.hit      = s2_hit_q && inside_page;
    s3_d.row      = s2_row_q[gpr_pkg::DimW-1:0];
    s3_d.col      = s2_col_q[gpr_pkg::DimW-1:0];
    if (s2_row_q < bh_ext) begin
      s3_d.band = gpr_pkg::BandUpper;
    end else if (s2_row_q < bh2_ext) begin
      s3_d.band = gpr_pkg::BandMiddle;
    end else begin
      s3_d.band = gpr_pkg::BandLower;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv_i) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_q <= s3_d;
    end
  end

  assign pix_valid_o = s3_v_q;
  assign pix_o       = s3_q;

endmodule

/* hdl/gpr_merge.sv */
module gpr_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  output logic                          adv_o,
  input  logic                          pix_valid_i,
  input  gpr_pkg::gpr_pix_t             pix_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pixel_valid_o,
  output logic [gpr_pkg::DimW-1:0]      pixel_row_o,
  output logic [gpr_pkg::DimW-1:0]      pixel_col_o,
  output logic [gpr_pkg::BandW-1:0]     band_o,
  output logic                          last_o
);

  // held pixel, waiting to learn whether it is the last of its character
  logic                         pend_v_q,    pend_v_d;
  logic                         pend_last_q, pend_last_d;
  logic [gpr_pkg::DimW-1:0]     pend_row_q,  pend_row_d;
  logic [gpr_pkg::DimW-1:0]     pend_col_q,  pend_col_d;
  logic [gpr_pkg::BandW-1:0]    pend_band_q, pend_band_d;
  logic                         seen_q,      seen_d;

  // output register
  logic                         out_v_q;
  logic                         emit;
  logic                         emit_pix;
  logic [gpr_pkg::DimW-1:0]     emit_row;
  logic [gpr_pkg::DimW-1:0]     emit_col;
  logic [gpr_pkg::BandW-1:0]    emit_band;
  logic                         emit_last;
  logic                         out_pix_q;
  logic [gpr_pkg::DimW-1:0]     out_row_q;
  logic [gpr_pkg::DimW-1:0]     out_col_q;
  logic [gpr_pkg::BandW-1:0]    out_band_q;
  logic                         out_last_q;

  // the whole pipeline moves whenever the output register can be loaded
  assign adv_o = !out_v_q || out_ready_i;

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_last_d = pend_last_q;
    pend_row_d  = pend_row_q;
    pend_col_d  = pend_col_q;
    pend_band_d = pend_band_q;
    seen_d      = seen_q;
    emit        = 1'b0;
    emit_pix    = 1'b1;
    emit_row    = pend_row_q;
    emit_col    = pend_col_q;
    emit_band   = pend_band_q;
    emit_last   = 1'b0;

    // a pixel already known to close its character goes out first
    if (pend_v_q && pend_last_q) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      pend_v_d  = 1'b0;
    end

    if (pix_valid_i) begin
      if (pix_i.hit) begin
        if (pend_v_q && !pend_last_q) begin
          emit = 1'b1;
        end
        pend_v_d    = 1'b1;
        pend_last_d = pix_i.end_slot;
        pend_row_d  = pix_i.row;
        pend_col_d  = pix_i.col;
        pend_band_d = pix_i.band;
      end else if (pix_i.end_slot) begin
        if (pend_v_q && !pend_last_q) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          pend_v_d  = 1'b0;
        end else if (!seen_q) begin
          // nothing drawn for this character
          emit      = 1'b1;
          emit_pix  = 1'b0;
          emit_row  = '0;
          emit_col  = '0;
          emit_band = gpr_pkg::BandUpper;
          emit_last = 1'b1;
        end
      end
      seen_d = pix_i.end_slot ? 1'b0 : (seen_q || pix_i.hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      seen_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else if (adv_o) begin
      pend_v_q <= pend_v_d;
      seen_q   <= seen_d;
      out_v_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pend_last_q <= pend_last_d;
      pend_row_q  <= pend_row_d;
      pend_col_q  <= pend_col_d;
      pend_band_q <= pend_band_d;
      if (emit) begin
        out_pix_q  <= emit_pix;
        out_row_q  <= emit_row;
        out_col_q  <= emit_col;
        out_band_q <= emit_band;
        out_last_q <= emit_last;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign pixel_valid_o = out_pix_q;
  assign pixel_row_o   = out_row_q;
  assign pixel_col_o   = out_col_q;
  assign band_o        = out_band_q;
  assign last_o        = out_last_q;

endmodule

/* bench/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxChars   = 120;
  localparam int CellWidth  = 8;
  localparam int CycleLimit = 1_000_000;

  // index range the block decodes to nothing
  localparam logic [2:0] CfgSpareFirst = 3'd5;
  localparam logic [2:0] CfgSpareLast  = 3'd7;

  // glyph rows 0..5 from the top two octal digits down, left dot in the msb of a row
  localparam logic [35:0] GlyphFont [64] = '{
    36'o364146514635, 36'o142241774141, 36'o764176414176, 36'o364140404136,
    36'o764141414176, 36'o774076404077, 36'o774076404040, 36'o364140474136,
    36'o414177414141, 36'o040404040404, 36'o010101014136, 36'o414274444241,
    36'o404040404077, 36'o416355414141, 36'o416151454341, 36'o364141414136,
    36'o764141764040, 36'o364141454235, 36'o764141764241, 36'o364036014136,
    36'o370404040404, 36'o414141414136, 36'o414141412214, 36'o414141556341,
    36'o412214142241, 36'o211204040404, 36'o770204102077, 36'o161010101016,
    36'o402010040201, 36'o340404040434, 36'o041200000000, 36'o000000000077,
    36'o000000000000, 36'o101010100010, 36'o222200000000, 36'o227722227722,
    36'o365436155536, 36'o016264132340, 36'o142214244235, 36'o101000000000,
    36'o041010101004, 36'o100404040410, 36'o002214142200, 36'o001010761010,
    36'o000060602040, 36'o000000760000, 36'o000000006060, 36'o010204102040,
    36'o142222222214, 36'o041404040437, 36'o162101162037, 36'o162101160136,
    36'o222222370202, 36'o372020360136, 36'o172036212116, 36'o370102041020,
    36'o162116212116, 36'o162121170116, 36'o003030003030, 36'o003030001020,
    36'o000000000000, 36'o000000000000, 36'o000000000000, 36'o000000000000
  };

  typedef struct packed {
    logic [gpr_pkg::CodeW-1:0]       code;
    logic [gpr_pkg::PosW-1:0]        position;
    logic signed [gpr_pkg::OrgW-1:0] origin_x;
    logic signed [gpr_pkg::OrgW-1:0] origin_y;
    logic                            vertical;
  } char_item_t;

  typedef struct packed {
    logic                      valid;
    logic [gpr_pkg::DimW-1:0]  row;
    logic [gpr_pkg::DimW-1:0]  col;
    logic [gpr_pkg::BandW-1:0] band;
    logic                      last;
  } pixel_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [gpr_pkg::CodeW-1:0]       char_code_i;
  logic [gpr_pkg::PosW-1:0]        char_position_i;
  logic signed [gpr_pkg::OrgW-1:0] origin_x_i;
  logic signed [gpr_pkg::OrgW-1:0] origin_y_i;
  logic                            vertical_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            pixel_valid_o;
  logic [gpr_pkg::DimW-1:0]        pixel_row_o;
  logic [gpr_pkg::DimW-1:0]        pixel_col_o;
  logic [gpr_pkg::BandW-1:0]       band_o;
  logic                            last_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [2:0]                      cfg_index_i;
  logic [gpr_pkg::DimW-1:0]        cfg_data_i;

  gpr_pkg::gpr_cfg_t page_cfg;
  pixel_t   pending_pixels[$];
  pixel_t   want_pixel;
  pixel_t   got_pixel;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       errors;
  int       cycles;
  int       chars_sent;
  int       pixels_drawn;
  int       empty_results;
  int       settings_used;

  glyph_pixel_rasterizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .char_position_i (char_position_i),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .vertical_i      (vertical_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_valid_o   (pixel_valid_o),
    .pixel_row_o     (pixel_row_o),
    .pixel_col_o     (pixel_col_o),
    .band_o          (band_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d pixels still due", $time, CycleLimit,
               pending_pixels.size());
      $display("** glyph_pixel_rasterizer: FAILED **");
      $finish;
    end
  end

  // random back-pressure on the pixel side
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // every pixel transfer against the oldest predicted pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_pixel = '{pixel_valid_o, pixel_row_o, pixel_col_o, band_o, last_o};
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel transfer with none due: valid=%0b row=%0d col=%0d band=%0d last=%0b",
                 $time, got_pixel.valid, got_pixel.row, got_pixel.col, got_pixel.band,
                 got_pixel.last);
        errors++;
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (got_pixel !== want_pixel) begin
          $display("%0t: pixel mismatch expected valid=%0b row=%0d col=%0d band=%0d last=%0b",
                   $time, want_pixel.valid, want_pixel.row, want_pixel.col, want_pixel.band,
                   want_pixel.last);
          $display("%0t:                  actual valid=%0b row=%0d col=%0d band=%0d last=%0b",
                   $time, got_pixel.valid, got_pixel.row, got_pixel.col, got_pixel.band,
                   got_pixel.last);
          errors++;
        end
        if (want_pixel.valid) pixels_drawn++;
        else empty_results++;
      end
    end
  end

  // expected page pixels of one character under the current register values
  function automatic void rasterize_char(input char_item_t it);
    pixel_t      drawn[$];
    pixel_t      pix;
    logic [6:0]  c;
    logic [35:0] bits;
    int          ox, oy, base, o, px, py, row, col, ph, bh;
    ox = int'(it.origin_x);
    oy = int'(it.origin_y);
    ph = int'(page_cfg.page_height);
    bh = int'(page_cfg.band_height);
    if (int'(it.position) < MaxChars) begin
      // fold lower case up, control codes to the hash glyph
      c = it.code;
      if (c >= 7'h60) c = c - 7'h20;
      if (c < 7'h20) c = {1'b0, gpr_pkg::GlyphHash};
      if (c > 7'h3F) c = c - 7'h40;
      bits = GlyphFont[c[5:0]];
      base = int'(it.position) * CellWidth;
      for (int r = 0; r < 6; r++) begin
        for (int d = 0; d < 6; d++) begin
          if (!bits[35 - (r * 6 + d)]) continue;
          o = base + d;
          if (it.vertical) begin
            px = ox + r;
            py = oy + o;
          end else begin
            px = ox + o;
            py = oy - r;
          end
          row = ph - py + int'(page_cfg.top_margin);
          col = px + int'(page_cfg.left_margin);
          if (row < 0 || row > ph || col < 0 || col > int'(page_cfg.page_width)) continue;
          pix.valid = 1'b1;
          pix.row   = row[gpr_pkg::DimW-1:0];
          pix.col   = col[gpr_pkg::DimW-1:0];
          pix.last  = 1'b0;
          if (row < bh) pix.band = gpr_pkg::BandUpper;
          else if (row < 2 * bh) pix.band = gpr_pkg::BandMiddle;
          else pix.band = gpr_pkg::BandLower;
          drawn.push_back(pix);
        end
      end
    end
    // nothing on the page still gives one closing result
    if (drawn.size() == 0) begin
      drawn.push_back('{1'b0, '0, '0, '0, 1'b1});
    end else begin
      drawn[drawn.size() - 1].last = 1'b1;
    end
    foreach (drawn[i]) pending_pixels.push_back(drawn[i]);
  endfunction

  function automatic char_item_t char_at(input logic [6:0] code, input int pos,
                                         input int ox, input int oy, input logic vert);
    char_item_t it;
    it.code     = code;
    it.position = pos[6:0];
    it.origin_x = ox[15:0];
    it.origin_y = oy[15:0];
    it.vertical = vert;
    return it;
  endfunction

  // mostly characters aimed at the page, the rest fully random
  function automatic char_item_t random_char();
    char_item_t it;
    int         sel, off, px0, py0;
    sel         = $urandom_range(0, 99);
    it.code     = 7'($urandom_range(0, 127));
    it.vertical = 1'($urandom_range(0, 1));
    if (sel < 25) begin
      it.position = 7'($urandom_range(0, 127));
      it.origin_x = 16'($urandom);
      it.origin_y = 16'($urandom);
    end else begin
      it.position = (sel < 90) ? 7'($urandom_range(0, 15)) : 7'($urandom_range(0, MaxChars - 1));
      off = int'(it.position) * CellWidth;
      px0 = int'($urandom_range(0, page_cfg.page_width)) - int'(page_cfg.left_margin) - 3;
      py0 = int'($urandom_range(0, page_cfg.page_height)) + int'(page_cfg.top_margin) + 3;
      if (it.vertical) begin
        it.origin_x = px0[15:0];
        it.origin_y = 16'(py0 - off - 5);
      end else begin
        it.origin_x = 16'(px0 - off);
        it.origin_y = py0[15:0];
      end
    end
    return it;
  endfunction

  // one character transfer, with random idle cycles ahead of it
  task automatic send_char(input char_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    char_code_i     <= it.code;
    char_position_i <= it.position;
    origin_x_i      <= it.origin_x;
    origin_y_i      <= it.origin_y;
    vertical_i      <= it.vertical;
    do @(posedge clk_i); while (!in_ready_o);
    rasterize_char(it);
    chars_sent++;
  endtask

  // stop sending until every due pixel has come out
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [gpr_pkg::DimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gpr_pkg::CfgPageHeight: page_cfg.page_height = data;
      gpr_pkg::CfgBandHeight: page_cfg.band_height = data;
      gpr_pkg::CfgPageWidth:  page_cfg.page_width  = data;
      gpr_pkg::CfgTopMargin:  page_cfg.top_margin  = data[gpr_pkg::MarginW-1:0];
      gpr_pkg::CfgLeftMargin: page_cfg.left_margin = data[gpr_pkg::MarginW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_page(input int ph, input int bh, input int pw, input int tm, input int lm);
    drain_pixels();
    write_reg(gpr_pkg::CfgPageHeight, ph[gpr_pkg::DimW-1:0]);
    write_reg(gpr_pkg::CfgBandHeight, bh[gpr_pkg::DimW-1:0]);
    write_reg(gpr_pkg::CfgPageWidth, pw[gpr_pkg::DimW-1:0]);
    write_reg(gpr_pkg::CfgTopMargin, tm[gpr_pkg::DimW-1:0]);
    write_reg(gpr_pkg::CfgLeftMargin, lm[gpr_pkg::DimW-1:0]);
    settings_used++;
  endtask

  // font folding, clipping and band edges under the reset register values
  task automatic test_reset_glyphs();
    send_idle_pct  = 10;
    recv_stall_pct = 30;
    send_char(char_at(7'h41, 0, 100, 1000, 1'b0));   // A
    send_char(char_at(7'h61, 1, 100, 1000, 1'b0));   // a folds to A
    send_char(char_at(7'h00, 2, 100, 1000, 1'b0));   // control code draws hash
    send_char(char_at(7'h1F, 3, 100, 1000, 1'b0));
    send_char(char_at(7'h7F, 4, 100, 1000, 1'b0));   // del folds to underscore
    send_char(char_at(7'h20, 5, 100, 1000, 1'b0));   // space is blank
    send_char(char_at(7'h3C, 6, 100, 1000, 1'b0));   // no glyph for < = > ?
    send_char(char_at(7'h7F - 7'h40, 7, 100, 1000, 1'b0));
    send_char(char_at(7'h40, 8, 100, 1000, 1'b0));   // @ wraps to glyph 0
    send_char(char_at(7'h60, 9, 100, 1000, 1'b0));   // backquote wraps too
    send_char(char_at(7'h57, 119, -900, 1200, 1'b0)); // last drawable position
    send_char(char_at(7'h57, 120, -900, 1200, 1'b0)); // too far along the label
    send_char(char_at(7'h57, 127, -900, 1200, 1'b0));
    send_char(char_at(7'h52, 3, 300, 500, 1'b1));    // rotated text
    send_char(char_at(7'h23, 0, -32768, 32767, 1'b0));
    send_char(char_at(7'h23, 0, 32767, -32768, 1'b1));
    send_char(char_at(7'h4D, 0, -3, 2, 1'b0));       // corner, partly clipped
    send_char(char_at(7'h38, 0, 0, 2040, 1'b0));     // top rows of the page
    send_char(char_at(7'h48, 0, 400, 2040 - 678, 1'b0)); // across upper/middle band
    send_char(char_at(7'h48, 0, 400, 2040 - 1358, 1'b1)); // rotated, just above the middle/lower band edge
    send_char(char_at(7'h45, 0, 790, 700, 1'b1));    // right edge, rotated
  endtask

  // register extremes, masking, ignored indexes, zero band and page height
  task automatic test_register_limits();
    set_page(8191, 1, 8191, 1023, 1023);
    send_char(char_at(7'h42, 0, 0, 1030, 1'b0));
    send_char(char_at(7'h57, 0, -1023, 1025, 1'b1));
    send_char(char_at(7'h23, 119, -900, 1100, 1'b0));
    set_page(1, 8191, 1, 0, 0);
    send_char(char_at(7'h48, 0, 0, 1, 1'b0));
    send_char(char_at(7'h2A, 0, 0, 1, 1'b1));
    set_page(2040, 0, 792, 0, 0);
    // margin data wider than the register keeps its low bits
    write_reg(gpr_pkg::CfgTopMargin, 13'h1FFF);
    write_reg(gpr_pkg::CfgLeftMargin, 13'h1C05);
    for (int i = CfgSpareFirst; i <= CfgSpareLast; i++) begin
      write_reg(i[2:0], (i == CfgSpareFirst) ? 13'h1555 : ((i == CfgSpareLast) ? 13'h1FFF : '0));
    end
    send_char(char_at(7'h45, 0, 100, 1100, 1'b0));
    send_char(char_at(7'h45, 2, 100, 1100, 1'b1));
    set_page(0, 680, 792, 0, 0);
    send_char(char_at(7'h4C, 0, 0, 0, 1'b0));
  endtask

  // random characters under a random page setup
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int ph;
    ph = $urandom_range(64, 8191);
    set_page(ph, $urandom_range(1, ph / 2), $urandom_range(16, 8191),
             $urandom_range(0, 1023), $urandom_range(0, 1023));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_char(random_char());
      if ($urandom_range(0, 39) == 0) drain_pixels();
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    char_code_i     <= '0;
    char_position_i <= '0;
    origin_x_i      <= '0;
    origin_y_i      <= '0;
    vertical_i      <= 1'b0;
    out_ready_i     <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= gpr_pkg::CfgPageHeight;
    cfg_data_i      <= '0;
    page_cfg        = '{13'd2040, 13'd680, 13'd792, 10'd0, 10'd0};
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_glyphs();
    test_register_limits();
    test_random_traffic(10, 84, 125);
    test_random_traffic(84, 10, 125);
    test_random_traffic(0, 0, 125);
    drain_pixels();

    $display("ran %0d characters over %0d page setups: %0d pixels drawn, %0d empty results",
             chars_sent, settings_used + 1, pixels_drawn, empty_results);
    if (errors == 0) begin
      $display("** glyph_pixel_rasterizer: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** glyph_pixel_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
